[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL
// Clocked concurrent checks, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/lbcs_pkg.sv]
// ----------------------------------------------------------------------------
// LED blink-code sequencer package
// Animation codes, LED bit positions and timing constants.
// ----------------------------------------------------------------------------
package lbcs_pkg;

  typedef enum logic [3:0] {
    MODE_NONE       = 4'd0,
    MODE_CONFIRM    = 4'd1,
    MODE_TIMEOUT    = 4'd2,
    MODE_SHUTDOWN   = 4'd3,
    MODE_STARTUP    = 4'd4,
    MODE_BATTERY    = 4'd5,
    MODE_THRESHOLD  = 4'd6,
    MODE_MULTIPLIER = 4'd7,
    MODE_ERRORS     = 4'd8
  } mode_t;

  typedef enum logic [1:0] {
    SWEEP_DOWN  = 2'd0,
    SWEEP_UP    = 2'd1,
    SWEEP_LEVEL = 2'd2,
    SWEEP_HOLD  = 2'd3
  } sweep_t;

  // led bits: red, green, blue
  localparam logic [2:0] LED_R = 3'b001;
  localparam logic [2:0] LED_G = 3'b010;
  localparam logic [2:0] LED_B = 3'b100;

  // startup pattern step boundaries
  localparam logic [7:0] MAJOR_END   = 8'd10;
  localparam logic [7:0] MINOR_END   = 8'd14;
  localparam logic [7:0] STARTUP_END = 8'd18;

  localparam logic [11:0] PWM_FULL     = 12'd3300;
  localparam logic [11:0] BRIGHT_START = 12'd132;
  localparam logic [11:0] LEVEL_UNIT   = 12'd66;
  localparam logic [11:0] HALF_UNIT    = 12'd33;
  localparam logic [11:0] BRIGHT_MAX   = 12'd3168;
  localparam logic [11:0] BRIGHT_MIN   = 12'd132;
  localparam logic [4:0]  MS_TICKS     = 5'd20;
  localparam logic [5:0]  LEVEL_TOP    = 6'd48;

endpackage

[hw/rtl/led_blink_code_sequencer.sv]
// Flow: a word accepted on the input is held in the input register, which loads at
// the accepting edge, and then loads the result register once the output is free.
// Throughput: one word per cycle while the output is not stalled.
// Reset (rst, synchronous, active high) empties both stages, clears mode,
// counters and LEDs, and sets brightness to 132 with the sweep counting up.
// ----------------------------------------------------------------------------
// LED blink-code sequencer
// Steps the LED animations on timer ticks and starts them on start words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_blink_code_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] animation, [7:4] blink_count, [13:8] battery_level, [15:14] zero
  input  logic [15:0] s_tdata,
  // [0] kind (0 tick, 1 start)
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] red_led, [1] green_led, [2] led_blue, [14:3] pwm_period,
  // [15] done_res, [19:16] active_mode, [23:20] zero
  output logic [23:0] m_tdata
);

  // input stage
  logic       in_valid;
  logic       in_kind;
  logic [3:0] in_anim;
  logic [3:0] in_count;
  logic [5:0] in_level;
  logic       adv;

  // sequencer state
  lbcs_pkg::mode_t  mode, mode_next;
  lbcs_pkg::sweep_t sweep_phase, sweep_phase_next;
  logic [7:0]  step_count, step_count_next;
  logic [2:0]  led_bits, led_bits_next;
  logic        pwm_phase, pwm_phase_next;
  logic        half_ms_toggle, half_ms_toggle_next;
  logic [4:0]  ms_count, ms_count_next;
  logic [11:0] brightness, brightness_next;
  logic [5:0]  battery_latch, battery_latch_next;

  // result
  logic [11:0] per;
  logic        done;

  // helpers
  logic [7:0]  step_inc;
  logic [7:0]  wait_end;
  logic [7:0]  two_n;
  logic [2:0]  trans_mask;
  logic [4:0]  ms_inc;
  logic [11:0] bright_up;
  logic [11:0] bright_dn;
  logic [11:0] level_bright;

  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind  <= s_tuser;
      in_anim  <= s_tdata[3:0];
      in_count <= s_tdata[7:4];
      in_level <= s_tdata[13:8];
    end
  end

  assign step_inc     = step_count + 8'd1;
  assign wait_end     = (mode == lbcs_pkg::MODE_SHUTDOWN) ? 8'd2 : 8'd4;
  assign trans_mask   = (mode == lbcs_pkg::MODE_CONFIRM) ? lbcs_pkg::LED_G : lbcs_pkg::LED_R;
  assign two_n        = {3'b000, in_count, 1'b0};
  assign ms_inc       = ms_count + 5'd1;
  assign bright_up    = brightness + lbcs_pkg::HALF_UNIT;
  assign bright_dn    = (brightness >= lbcs_pkg::HALF_UNIT) ?
                        brightness - lbcs_pkg::HALF_UNIT : 12'd0;
  assign level_bright = 12'({6'b0, battery_latch} * lbcs_pkg::LEVEL_UNIT);

  // next state
  always_comb begin
    mode_next           = mode;
    sweep_phase_next    = sweep_phase;
    step_count_next     = step_count;
    led_bits_next       = led_bits;
    pwm_phase_next      = pwm_phase;
    half_ms_toggle_next = half_ms_toggle;
    ms_count_next       = ms_count;
    brightness_next     = brightness;
    battery_latch_next  = battery_latch;
    if (in_kind) begin
      // start word; unknown animation codes are dropped
      if (in_anim <= 4'(lbcs_pkg::MODE_ERRORS)) begin
        led_bits_next       = led_bits & lbcs_pkg::LED_B;
        step_count_next     = 8'd0;
        pwm_phase_next      = 1'b0;
        half_ms_toggle_next = 1'b0;
        ms_count_next       = 5'd0;
        brightness_next     = lbcs_pkg::BRIGHT_START;
        sweep_phase_next    = lbcs_pkg::SWEEP_UP;
        battery_latch_next  = (in_level > lbcs_pkg::LEVEL_TOP) ? lbcs_pkg::LEVEL_TOP : in_level;
        mode_next           = lbcs_pkg::mode_t'(in_anim);
      end
    end else begin
      case (mode)
        lbcs_pkg::MODE_CONFIRM, lbcs_pkg::MODE_TIMEOUT, lbcs_pkg::MODE_SHUTDOWN: begin
          if (step_count < wait_end) begin
            step_count_next = step_inc;
          end else if (step_count < 8'd8) begin
            led_bits_next   = led_bits ^ trans_mask;
            step_count_next = step_inc;
          end else if (mode != lbcs_pkg::MODE_SHUTDOWN && step_count < 8'd12) begin
            step_count_next = step_inc;
          end else begin
            mode_next       = lbcs_pkg::MODE_NONE;
            step_count_next = 8'd0;
          end
        end
        lbcs_pkg::MODE_STARTUP: begin
          if (step_count < 8'd2) begin
            led_bits_next   = led_bits ^ (lbcs_pkg::LED_R | lbcs_pkg::LED_G | lbcs_pkg::LED_B);
            step_count_next = step_inc;
          end else if (step_count < 8'd6) begin
            step_count_next = step_inc;
          end else if (step_count < lbcs_pkg::MAJOR_END) begin
            led_bits_next   = led_bits ^ lbcs_pkg::LED_R;
            step_count_next = step_inc;
          end else if (step_count < lbcs_pkg::MINOR_END) begin
            led_bits_next   = led_bits ^ lbcs_pkg::LED_G;
            step_count_next = step_inc;
          end else if (step_count < lbcs_pkg::STARTUP_END) begin
            step_count_next = step_inc;
          end else begin
            // hand over to battery display, latch kept
            led_bits_next       = led_bits & lbcs_pkg::LED_B;
            step_count_next     = 8'd0;
            pwm_phase_next      = 1'b0;
            half_ms_toggle_next = 1'b0;
            ms_count_next       = 5'd0;
            brightness_next     = lbcs_pkg::BRIGHT_START;
            sweep_phase_next    = lbcs_pkg::SWEEP_UP;
            mode_next           = lbcs_pkg::MODE_BATTERY;
          end
        end
        lbcs_pkg::MODE_BATTERY: begin
          pwm_phase_next = ~pwm_phase;
          if (!pwm_phase) begin
            led_bits_next = (led_bits | lbcs_pkg::LED_G) & ~lbcs_pkg::LED_R;
          end else begin
            led_bits_next = (led_bits | lbcs_pkg::LED_R) & ~lbcs_pkg::LED_G;
          end
          if (!half_ms_toggle) begin
            half_ms_toggle_next = 1'b1;
          end else begin
            half_ms_toggle_next = 1'b0;
            if (sweep_phase != lbcs_pkg::SWEEP_HOLD) begin
              if (ms_inc < lbcs_pkg::MS_TICKS) begin
                ms_count_next = ms_inc;
              end else begin
                ms_count_next = 5'd0;
                case (sweep_phase)
                  lbcs_pkg::SWEEP_UP: begin
                    brightness_next = bright_up;
                    if (bright_up >= lbcs_pkg::BRIGHT_MAX) begin
                      sweep_phase_next = lbcs_pkg::SWEEP_DOWN;
                    end
                  end
                  lbcs_pkg::SWEEP_DOWN: begin
                    brightness_next = bright_dn;
                    if (bright_dn <= lbcs_pkg::BRIGHT_MIN) begin
                      sweep_phase_next = lbcs_pkg::SWEEP_LEVEL;
                    end
                  end
                  default: begin
                    if (brightness <= level_bright) begin
                      brightness_next = bright_up;
                    end else begin
                      sweep_phase_next = lbcs_pkg::SWEEP_HOLD;
                    end
                  end
                endcase
              end
            end
          end
        end
        lbcs_pkg::MODE_THRESHOLD, lbcs_pkg::MODE_MULTIPLIER, lbcs_pkg::MODE_ERRORS: begin
          if (step_count < two_n) begin
            case (mode)
              lbcs_pkg::MODE_THRESHOLD: led_bits_next = led_bits ^ lbcs_pkg::LED_G;
              lbcs_pkg::MODE_MULTIPLIER: begin
                led_bits_next = led_bits ^ (lbcs_pkg::LED_G | lbcs_pkg::LED_R);
              end
              default: led_bits_next = led_bits ^ lbcs_pkg::LED_R;
            endcase
            step_count_next = step_inc;
          end else if (step_inc > two_n + 8'd8) begin
            // end of the 9-tick pause
            step_count_next = 8'd0;
          end else begin
            step_count_next = step_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // result fields
  always_comb begin
    per  = 12'd0;
    done = 1'b0;
    if (!in_kind) begin
      case (mode)
        lbcs_pkg::MODE_CONFIRM, lbcs_pkg::MODE_TIMEOUT: done = (step_count >= 8'd12);
        lbcs_pkg::MODE_SHUTDOWN: done = (step_count >= 8'd8);
        lbcs_pkg::MODE_STARTUP:  done = (step_count >= lbcs_pkg::STARTUP_END);
        lbcs_pkg::MODE_BATTERY: begin
          if (!pwm_phase) begin
            per = (brightness <= lbcs_pkg::PWM_FULL) ? lbcs_pkg::PWM_FULL - brightness : 12'd0;
          end else begin
            per = brightness;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= lbcs_pkg::MODE_NONE;
      sweep_phase    <= lbcs_pkg::SWEEP_UP;
      step_count     <= 8'd0;
      led_bits       <= 3'b000;
      pwm_phase      <= 1'b0;
      half_ms_toggle <= 1'b0;
      ms_count       <= 5'd0;
      brightness     <= lbcs_pkg::BRIGHT_START;
      battery_latch  <= 6'd0;
    end else if (adv) begin
      mode           <= mode_next;
      sweep_phase    <= sweep_phase_next;
      step_count     <= step_count_next;
      led_bits       <= led_bits_next;
      pwm_phase      <= pwm_phase_next;
      half_ms_toggle <= half_ms_toggle_next;
      ms_count       <= ms_count_next;
      brightness     <= brightness_next;
      battery_latch  <= battery_latch_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= {4'b0000, 4'(mode_next), done, per,
                  led_bits_next[2], led_bits_next[1], led_bits_next[0]};
    end
  end

  `ASSERT_ALWAYS(a_ms_range, clk, rst, ms_count < lbcs_pkg::MS_TICKS, "ms_count out of range")
  `ASSERT_IMPLIES(a_done_mode, clk, rst, m_tvalid && m_tdata[15],
    m_tdata[19:16] == 4'(lbcs_pkg::MODE_NONE) || m_tdata[19:16] == 4'(lbcs_pkg::MODE_BATTERY),
    "done flagged with a running pattern")
  `ASSERT_NEXT(a_take_in, clk, rst, s_tvalid && s_tready, in_valid,
    "accepted word not held in input stage")

endmodule
